// File: rtl/tst_pkg.sv
package tst_pkg;

    localparam int unsigned SLOTS_DEFAULT = 256;

    localparam int unsigned CMD_W  = 3;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned SLOT_W = 9;
    localparam int unsigned SEQ_W  = 16;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned IDX_W  = 8;
    localparam int unsigned WORD_W = ADDR_W + SEQ_W;

    localparam logic [CMD_W-1:0] CMD_RECEIVE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ASSIGN  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUP = 2'd1;
    localparam logic [STAT_W-1:0] ST_ERR = 2'd2;

    typedef struct packed {
        logic load;
        logic cnt_clear;
        logic clr_step;
        logic lookup_rd;
        logic lookup_done;
        logic assign_wr;
        logic scan_step;
        logic place;
        logic set_err;
        logic set_ok;
        logic out_load;
    } tst_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             slot_ok;
        logic             cnt_last;
        logic             scan_done;
        logic             free_found;
        logic             out_free;
    } tst_sts_t;

endpackage

// File: rtl/terminal_slot_table_unit.sv
// channel | direction | beat fields
// in      | in        | command, terminal_address, slot, sequence_req
// out     | out       | status, entry_address, entry_sequence, entry_index
//
// One command at a time. Add and delete sweep every slot through
// the single read port of the slot memory, one slot per cycle.
// After reset a clearing pass writes every slot to zero;
// in_stall stays high until it ends.
// A stalled output beat is held in its register; the next command is taken
// meanwhile and its result waits until the output register frees.
module terminal_slot_table_unit #(
    parameter int unsigned SLOTS = tst_pkg::SLOTS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tst_pkg::CMD_W-1:0]   command,
    input  logic [tst_pkg::ADDR_W-1:0]  terminal_address,
    input  logic [tst_pkg::SLOT_W-1:0]  slot,
    input  logic [tst_pkg::SEQ_W-1:0]   sequence_req,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tst_pkg::STAT_W-1:0]  status,
    output logic [tst_pkg::ADDR_W-1:0]  entry_address,
    output logic [tst_pkg::SEQ_W-1:0]   entry_sequence,
    output logic [tst_pkg::IDX_W-1:0]   entry_index
);
    import tst_pkg::*;

    tst_ctl_t ctl;
    tst_sts_t sts;

    tst_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sts     (sts),
        .ctl     (ctl)
    );

    tst_datapath #(
        .SLOTS(SLOTS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .command         (command),
        .terminal_address(terminal_address),
        .slot            (slot),
        .sequence_req    (sequence_req),
        .ctl             (ctl),
        .sts             (sts),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .entry_address   (entry_address),
        .entry_sequence  (entry_sequence),
        .entry_index     (entry_index)
    );

endmodule

// File: rtl/tst_ram.sv
module tst_ram #(
    parameter int unsigned WIDTH = tst_pkg::WORD_W,
    parameter int unsigned DEPTH = tst_pkg::SLOTS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/tst_ctrl.sv
module tst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  tst_pkg::tst_sts_t sts,
    output tst_pkg::tst_ctl_t ctl
);
    import tst_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_LOOKUP = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_PLACE  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.cmd)
                    CMD_RECEIVE, CMD_READ:
                    begin
                        if (sts.slot_ok)
                        begin
                            ctl.lookup_rd = 1'b1;
                            state_next    = S_LOOKUP;
                        end
                        else
                        begin
                            ctl.set_err = 1'b1;
                            state_next  = S_FINISH;
                        end
                    end
                    CMD_ASSIGN:
                    begin
                        if (sts.slot_ok)
                        begin
                            ctl.assign_wr = 1'b1;
                        end
                        else
                        begin
                            ctl.set_err = 1'b1;
                        end
                        state_next = S_FINISH;
                    end
                    CMD_ADD, CMD_DELETE:
                    begin
                        ctl.cnt_clear = 1'b1;
                        state_next    = S_SCAN;
                    end
                    default:
                    begin
                        ctl.set_err = 1'b1;
                        state_next  = S_FINISH;
                    end
                endcase
            end
            S_LOOKUP:
            begin
                ctl.lookup_done = 1'b1;
                state_next      = S_FINISH;
            end
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    if (sts.cmd == CMD_ADD)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        ctl.set_ok = 1'b1;
                        state_next = S_FINISH;
                    end
                end
            end
            S_PLACE:
            begin
                if (sts.free_found)
                begin
                    ctl.place = 1'b1;
                end
                else
                begin
                    ctl.set_err = 1'b1;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/tst_datapath.sv
module tst_datapath #(
    parameter int unsigned SLOTS = tst_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [tst_pkg::CMD_W-1:0]    command,
    input  logic [tst_pkg::ADDR_W-1:0]   terminal_address,
    input  logic [tst_pkg::SLOT_W-1:0]   slot,
    input  logic [tst_pkg::SEQ_W-1:0]    sequence_req,
    input  tst_pkg::tst_ctl_t            ctl,
    output tst_pkg::tst_sts_t            sts,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tst_pkg::STAT_W-1:0]   status,
    output logic [tst_pkg::ADDR_W-1:0]   entry_address,
    output logic [tst_pkg::SEQ_W-1:0]    entry_sequence,
    output logic [tst_pkg::IDX_W-1:0]    entry_index
);
    import tst_pkg::*;

    localparam int unsigned AW = $clog2(SLOTS);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned SW = (CW > SLOT_W) ? CW : SLOT_W;

    logic [CMD_W-1:0]  cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SEQ_W-1:0]  seq_reg;

    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_prev;
    logic              found_reg;
    logic [AW-1:0]     free_idx_reg;

    logic [STAT_W-1:0] res_status_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    logic [SEQ_W-1:0]  res_seq_reg;
    logic [IDX_W-1:0]  res_idx_reg;

    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [SEQ_W-1:0]  out_seq_reg;
    logic [IDX_W-1:0]  out_idx_reg;

    logic [SW-1:0]     slot_ext;
    logic [SW-1:0]     lk_full;
    logic [AW-1:0]     lk_idx;
    logic              slot_ok;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic [ADDR_W-1:0] rd_addr_f;
    logic [SEQ_W-1:0]  rd_seq_f;

    logic              scan_proc;
    logic              scan_match;
    logic              scan_free;
    logic              addr_hit;
    logic              rcv_wr;

    assign slot_ext  = SW'(slot_reg);
    assign lk_full   = (cmd_reg == CMD_RECEIVE) ? (slot_ext - SW'(1)) : slot_ext;
    assign lk_idx    = lk_full[AW-1:0];
    assign cnt_prev  = cnt_reg - CW'(1);
    assign rd_addr_f = rd_data[WORD_W-1:SEQ_W];
    assign rd_seq_f  = rd_data[SEQ_W-1:0];

    always_comb
    begin
        case (cmd_reg)
            CMD_RECEIVE:         slot_ok = (slot_ext != '0) && (slot_ext <= SW'(SLOTS));
            CMD_ASSIGN, CMD_READ: slot_ok = (slot_ext < SW'(SLOTS));
            default:             slot_ok = 1'b0;
        endcase
    end

    assign scan_proc  = ctl.scan_step && (cnt_reg != '0);
    assign scan_match = (rd_addr_f == addr_reg);
    assign scan_free  = (rd_addr_f == '0) || scan_match;
    assign addr_hit   = (addr_reg == rd_addr_f);
    assign rcv_wr     = ctl.lookup_done && (cmd_reg == CMD_RECEIVE) &&
                        ((addr_hit && (seq_reg != rd_seq_f)) ||
                         (!addr_hit && (rd_addr_f == '0)));

    assign rd_addr = ctl.lookup_rd ? lk_idx : cnt_reg[AW-1:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg[AW-1:0];
        wr_data = '0;
        if (ctl.clr_step)
        begin
            wr_en = 1'b1;
        end
        else if (ctl.assign_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = lk_idx;
            wr_data = {addr_reg, SEQ_W'(0)};
        end
        else if (rcv_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = lk_idx;
            wr_data = {addr_reg, seq_reg};
        end
        else if (scan_proc && scan_match)
        begin
            wr_en   = 1'b1;
            wr_addr = cnt_prev[AW-1:0];
        end
        else if (ctl.place)
        begin
            wr_en   = 1'b1;
            wr_addr = free_idx_reg;
            wr_data = {addr_reg, SEQ_W'(0)};
        end
    end

    tst_ram #(
        .WIDTH(WORD_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= command;
            addr_reg <= terminal_address;
            slot_reg <= slot;
            seq_reg  <= sequence_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (ctl.cnt_clear)
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (ctl.clr_step || ctl.scan_step)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                if (scan_proc && scan_free && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_proc && scan_free && !found_reg)
        begin
            free_idx_reg <= cnt_prev[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.set_err)
        begin
            res_status_reg <= ST_ERR;
            res_addr_reg   <= '0;
            res_seq_reg    <= '0;
            res_idx_reg    <= '0;
        end
        else if (ctl.set_ok || ctl.assign_wr)
        begin
            res_status_reg <= ST_OK;
            res_addr_reg   <= '0;
            res_seq_reg    <= '0;
            res_idx_reg    <= '0;
        end
        else if (ctl.place)
        begin
            res_status_reg <= ST_OK;
            res_addr_reg   <= addr_reg;
            res_seq_reg    <= '0;
            res_idx_reg    <= IDX_W'(free_idx_reg);
        end
        else if (ctl.lookup_done)
        begin
            if (cmd_reg == CMD_READ)
            begin
                res_status_reg <= ST_OK;
                res_addr_reg   <= rd_addr_f;
                res_seq_reg    <= rd_seq_f;
                res_idx_reg    <= IDX_W'(lk_idx);
            end
            else
            begin
                if (addr_hit)
                begin
                    res_status_reg <= (seq_reg != rd_seq_f) ? ST_OK : ST_DUP;
                end
                else
                begin
                    res_status_reg <= (rd_addr_f == '0) ? ST_OK : ST_ERR;
                end
                res_addr_reg <= '0;
                res_seq_reg  <= '0;
                res_idx_reg  <= '0;
            end
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_seq_reg    <= res_seq_reg;
            out_idx_reg    <= res_idx_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign entry_address  = out_addr_reg;
    assign entry_sequence = out_seq_reg;
    assign entry_index    = out_idx_reg;

    assign sts.cmd        = cmd_reg;
    assign sts.slot_ok    = slot_ok;
    assign sts.cnt_last   = (cnt_reg == CW'(SLOTS - 1));
    assign sts.scan_done  = (cnt_reg == CW'(SLOTS));
    assign sts.free_found = found_reg;
    assign sts.out_free   = !out_valid_reg || !out_stall;

endmodule

// File: rtl/tst_checker.sv
module tst_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [tst_pkg::CMD_W-1:0]   command,
    input logic [tst_pkg::ADDR_W-1:0]  terminal_address,
    input logic [tst_pkg::SLOT_W-1:0]  slot,
    input logic [tst_pkg::SEQ_W-1:0]   sequence_req,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [tst_pkg::STAT_W-1:0]  status,
    input logic [tst_pkg::ADDR_W-1:0]  entry_address,
    input logic [tst_pkg::SEQ_W-1:0]   entry_sequence,
    input logic [tst_pkg::IDX_W-1:0]   entry_index
);
    import tst_pkg::*;

    // held input beat
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(command) &&
        $stable(terminal_address) && $stable(slot) && $stable(sequence_req))
        else $error("input beat changed while stalled");

    // held output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) &&
        $stable(entry_address) && $stable(entry_sequence) && $stable(entry_index))
        else $error("output beat changed while stalled");

    // one command in flight: busy right after an accepted beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a command is in flight");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ERR) |->
        (entry_address == '0) && (entry_sequence == '0) && (entry_index == '0))
        else $error("error beat carries entry data");

    a_dup_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_DUP) |->
        (entry_address == '0) && (entry_sequence == '0) && (entry_index == '0))
        else $error("duplicate beat carries entry data");

endmodule

bind terminal_slot_table_unit tst_checker u_tst_checker (.*);
